// ----- rtl/spq_pkg.sv -----
// shared constants, codes and control types of the sorted priority queue
package spq_pkg;

  localparam int DEPTH_DEF  = 8;
  localparam int LEVELS_DEF = 10;

  localparam int PRIO_W   = 4;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 4;

  localparam logic [TAG_W-1:0] TAG_MAX = 16'hFFFF;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_SERVE  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming item and set up the walk
    logic rd;     // read the store at the walk index and step it
    logic fin;    // commit the item and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;       // incoming item needs no walk
    logic last;       // current walk index is the last one
    logic slot_free;  // result register can take a new result
  } stat_t;

endpackage

// ----- rtl/spq_req_if.sv -----
// request channel of the sorted priority queue
interface spq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [spq_pkg::PRIO_W-1:0] priority_req;

  modport source (output valid, output mode, output priority_req, input ready);
  modport sink (input valid, input mode, input priority_req, output ready);
endinterface

// ----- rtl/spq_rsp_if.sv -----
// result channel of the sorted priority queue
interface spq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic [spq_pkg::TAG_W-1:0]    tag;
  logic [spq_pkg::PRIO_W-1:0]   served_priority;
  logic [spq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output tag, output served_priority,
                  output occupancy, input ready);
  modport sink (input valid, input status, input tag, input served_priority,
                input occupancy, output ready);
endinterface

// ----- rtl/sorted_priority_queue.sv -----
// top level of the sorted priority queue: controller plus store datapath
//
// usage:
//   req channel carries one item per transfer: mode 0 inserts a request with
//   priority_req (values above LEVELS-1 are clamped), mode 1 serves the
//   highest-priority entry, oldest first among equal priorities.
//   rsp channel returns exactly one result per item: status, tag,
//   served_priority and occupancy after the item.
//   inserts get a tag one above the largest tag held (1 when empty),
//   saturating at 65535; a full insert or an empty serve leaves the queue as is.
// timing:
//   an item walks over every entry held, going from idle through the walk and
//   drain steps to its commit; the next item is taken only after that commit.
//   Full inserts, empty serves and inserts into an empty queue go straight
//   from idle to commit. The walk over the store reads one entry per cycle,
//   which both shifts entries and finds the largest tag.
// reset:
//   synchronous rst empties the queue and drops any pending result.
// back-pressure:
//   a result waits in the output register while rsp.ready is low; the next
//   item is still taken and walked, and it holds in its commit step until
//   the register drains.
module sorted_priority_queue #(
  parameter int DEPTH  = spq_pkg::DEPTH_DEF,
  parameter int LEVELS = spq_pkg::LEVELS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  // command and status between the sequencer and the store
  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t st;

  // sequencer: idle, walk, drain the last read, commit
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // sorted store, walk logic and result register
  spq_dp #(
    .DEPTH  (DEPTH),
    .LEVELS (LEVELS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .st                  (st),
    .req_mode            (req.mode),
    .req_priority        (req.priority_req),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_tag             (rsp.tag),
    .rsp_served_priority (rsp.served_priority),
    .rsp_occupancy       (rsp.occupancy)
  );

endmodule

// ----- rtl/spq_ctrl.sv -----
// sequencing state machine of the sorted priority queue
module spq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  spq_pkg::stat_t  st,
  output spq_pkg::cmd_t   cmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      spq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = st.skip ? spq_pkg::S_FINISH : spq_pkg::S_WALK;
        end
      end
      spq_pkg::S_WALK: begin
        cmd.rd = 1'b1;
        if (st.last) begin
          state_next = spq_pkg::S_DRAIN;
        end
      end
      // last read word is folded in here
      spq_pkg::S_DRAIN: begin
        state_next = spq_pkg::S_FINISH;
      end
      spq_pkg::S_FINISH: begin
        if (st.slot_free) begin
          cmd.fin    = 1'b1;
          state_next = spq_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule

// ----- rtl/spq_dp.sv -----
// sorted store, walk registers and result register of the sorted priority queue
module spq_dp #(
  parameter int DEPTH  = spq_pkg::DEPTH_DEF,
  parameter int LEVELS = spq_pkg::LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  spq_pkg::cmd_t                cmd,
  output spq_pkg::stat_t               st,
  input  logic                         req_mode,
  input  logic [spq_pkg::PRIO_W-1:0]   req_priority,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [spq_pkg::STATUS_W-1:0] rsp_status,
  output logic [spq_pkg::TAG_W-1:0]    rsp_tag,
  output logic [spq_pkg::PRIO_W-1:0]   rsp_served_priority,
  output logic [spq_pkg::OCC_W-1:0]    rsp_occupancy
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [spq_pkg::PRIO_W-1:0] PRIO_TOP = spq_pkg::PRIO_W'(LEVELS - 1);

  // sorted store, index 0 is served next
  logic [spq_pkg::PRIO_W-1:0] mem_prio [DEPTH];
  logic [spq_pkg::TAG_W-1:0]  mem_tag  [DEPTH];

  logic [CW-1:0]              cnt;
  logic [CW-1:0]              cnt_next;
  logic [CW-1:0]              cnt_m1;

  // item under work
  logic                       mode;
  logic [spq_pkg::PRIO_W-1:0] prio;
  logic                       reject;
  logic [spq_pkg::PRIO_W-1:0] prio_sat;
  logic                       req_full;
  logic                       req_empty;

  // walk
  logic [IW-1:0]              idx;
  logic [IW-1:0]              rd_idx;
  logic                       rd_pend;
  logic [spq_pkg::PRIO_W-1:0] rd_prio;
  logic [spq_pkg::TAG_W-1:0]  rd_tag;
  logic [spq_pkg::TAG_W-1:0]  max_tag;
  logic [spq_pkg::TAG_W-1:0]  new_tag;
  logic                       shifting;
  logic [IW-1:0]              pos;
  logic [spq_pkg::PRIO_W-1:0] head_prio;
  logic [spq_pkg::TAG_W-1:0]  head_tag;

  // store write port
  logic                       wr_en;
  logic [IW-1:0]              wr_addr;
  logic [spq_pkg::PRIO_W-1:0] wr_prio;
  logic [spq_pkg::TAG_W-1:0]  wr_tag;

  logic [CW+spq_pkg::OCC_W-1:0] occ_wide;

  assign cnt_m1    = cnt - CW'(1);
  assign req_full  = (cnt == CNT_FULL);
  assign req_empty = (cnt == '0);
  assign prio_sat  = (req_priority > PRIO_TOP) ? PRIO_TOP : req_priority;
  assign new_tag   = (max_tag == spq_pkg::TAG_MAX) ? spq_pkg::TAG_MAX
                                                   : max_tag + spq_pkg::TAG_W'(1);

  // status toward the controller
  always_comb begin
    st.skip      = (req_mode == spq_pkg::MODE_INSERT) ? (req_full || req_empty) : req_empty;
    st.last      = (mode == spq_pkg::MODE_INSERT) ? (idx == '0) : (CW'(idx) == cnt_m1);
    st.slot_free = !rsp_valid || rsp_ready;
  end

  // one write a cycle: a shifted word during the walk, the new entry at the end
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_prio = prio;
    wr_tag  = new_tag;
    if (cmd.fin && !reject && (mode == spq_pkg::MODE_INSERT)) begin
      wr_en = 1'b1;
    end else if (rd_pend) begin
      if (mode == spq_pkg::MODE_INSERT) begin
        if (shifting && (rd_prio < prio)) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx + IW'(1);
          wr_prio = rd_prio;
          wr_tag  = rd_tag;
        end
      end else if (rd_idx != '0) begin
        wr_en   = 1'b1;
        wr_addr = rd_idx - IW'(1);
        wr_prio = rd_prio;
        wr_tag  = rd_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_prio[wr_addr] <= wr_prio;
      mem_tag[wr_addr]  <= wr_tag;
    end
    if (cmd.rd) begin
      rd_prio <= mem_prio[idx];
      rd_tag  <= mem_tag[idx];
      rd_idx  <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd;
    end
  end

  // item capture and walk bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode     <= req_mode;
      prio     <= prio_sat;
      reject   <= (req_mode == spq_pkg::MODE_INSERT) ? req_full : req_empty;
      idx      <= (req_mode == spq_pkg::MODE_INSERT) ? cnt_m1[IW-1:0] : '0;
      pos      <= cnt[IW-1:0];
      max_tag  <= '0;
      shifting <= 1'b1;
    end else if (cmd.rd) begin
      idx <= (mode == spq_pkg::MODE_INSERT) ? idx - IW'(1) : idx + IW'(1);
    end
    if (rd_pend) begin
      if (rd_tag > max_tag) begin
        max_tag <= rd_tag;
      end
      if (mode == spq_pkg::MODE_INSERT) begin
        if (shifting && (rd_prio < prio)) begin
          pos <= rd_idx;
        end else begin
          shifting <= 1'b0;
        end
      end else if (rd_idx == '0) begin
        head_prio <= rd_prio;
        head_tag  <= rd_tag;
      end
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (!reject) begin
      cnt_next = (mode == spq_pkg::MODE_INSERT) ? cnt + CW'(1) : cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.fin) begin
      cnt <= cnt_next;
    end
  end

  assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, cnt_next};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.fin) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      rsp_occupancy <= occ_wide[spq_pkg::OCC_W-1:0];
      if (mode == spq_pkg::MODE_INSERT) begin
        rsp_status          <= reject ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
        rsp_tag             <= reject ? '0 : new_tag;
        rsp_served_priority <= '0;
      end else begin
        rsp_status          <= reject ? spq_pkg::ST_EMPTY : spq_pkg::ST_SERVED;
        rsp_tag             <= reject ? '0 : head_tag;
        rsp_served_priority <= reject ? '0 : head_prio;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_FULL)
    else $error("entry count above depth");

  a_fin_after_walk: assert property (@(posedge clk) disable iff (rst) cmd.fin |-> !rd_pend)
    else $error("commit while a read word is still in flight");

  a_insert_tag: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == spq_pkg::ST_INSERTED)) |-> (rsp_tag != '0))
    else $error("inserted entry got a zero tag");

  a_cnt_moves: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin && !reject) |=> (cnt != $past(cnt)))
    else $error("accepted insert or serve left the count unchanged");

endmodule
